>>> hdl/hole_fill_3x3_neighbor_average_defines.svh
// Assertion macros shared by the hole filling modules.
// Each macro expects the clock aclk and the active-low reset aresetn in scope.
`ifndef HOLE_FILL_3X3_NEIGHBOR_AVERAGE_DEFINES_SVH
`define HOLE_FILL_3X3_NEIGHBOR_AVERAGE_DEFINES_SVH

// The condition holds at every clock edge outside reset.
`define HF_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// The consequence holds at the same edge as the antecedent.
`define HF_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequence holds at the clock edge that follows the antecedent.
`define HF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/hf_pkg.sv
// Shared types, constants and helper functions of the 3x3 hole filling block.
// No dependencies.
`timescale 1ns / 1ps

package hf_pkg;

    localparam int MAX_WIDTH_DEFAULT  = 1024;
    localparam int MAX_HEIGHT_DEFAULT = 4096;
    localparam int MIN_SIZE           = 3;
    localparam int QUEUE_DEPTH        = 4;

    localparam int FRAME_WIDTH_RESET  = 640;
    localparam int FRAME_HEIGHT_RESET = 480;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_WIDTH_W = 11;

    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 8'd1;

    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 48;
    localparam int ROW_W    = 12;
    localparam int COLUMN_W = 10;
    localparam int SUM_W    = 11;
    localparam int COUNT_W  = 4;
    localparam int RECIP_W  = 17;
    localparam int RECIP_SHIFT = 16;
    localparam int PROD_W   = SUM_W + RECIP_W;

    typedef struct packed {
        logic       filled;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    localparam int PIXEL_W = $bits(pixel_t);

    typedef struct packed {
        logic                emit_interior;
        logic                emit_border;
        logic [ROW_W-1:0]    row;
        logic [COLUMN_W-1:0] column;
        pixel_t              centre;
        pixel_t              current;
        logic [SUM_W-1:0]    sum_red;
        logic [SUM_W-1:0]    sum_green;
        logic [SUM_W-1:0]    sum_blue;
        logic [COUNT_W-1:0]  count;
    } job_t;

    function automatic logic [31:0] clamp_size(input logic [31:0] v, input logic [31:0] hi);
        logic [31:0] r;
        if (v < 32'(MIN_SIZE)) begin
            r = 32'(MIN_SIZE);
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Scaled reciprocal ceil(2^16 / n); exact for sums up to 8 * 255.
    function automatic logic [RECIP_W-1:0] recip(input logic [COUNT_W-1:0] n);
        logic [RECIP_W-1:0] r;
        unique case (n)
            4'd1:    r = 17'd65536;
            4'd2:    r = 17'd32768;
            4'd3:    r = 17'd21846;
            4'd4:    r = 17'd16384;
            4'd5:    r = 17'd13108;
            4'd6:    r = 17'd10923;
            4'd7:    r = 17'd9363;
            4'd8:    r = 17'd8192;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

>>> hdl/hole_fill_3x3_neighbor_average.sv
// Top level of the 3x3 neighbor average hole filling block.
// Depends on hf_pkg, hf_front, hf_queue and hf_back.
//
// Pixels enter in raster order, one per request, with their filled mark on s_tuser.
// Each pixel is accepted while the four-entry job queue has room; the window stage
// and the one-port-read line store (MAX_WIDTH entries rounded up to a power of two,
// two pixels each) take one item per cycle unless the queue is full. Results leave
// one per clock through the output register unless m_tready stalls it; a pixel that
// causes two results (the interior pixel up and left of it, then itself on the frame
// border) emits both in turn; a sustained rate near one pixel per clock holds away
// from the right and bottom border. The line store needs no clearing pass; the first
// two rows of each frame write it before it is read. frame_width (index 0) and
// frame_height (index 1) must be written through cfg_* only while the block is idle,
// which it does not enforce; writes take effect at once and restart at row 0, column 0.
`timescale 1ns / 1ps

module hole_fill_3x3_neighbor_average #(
    parameter int MAX_WIDTH  = hf_pkg::MAX_WIDTH_DEFAULT,
    parameter int MAX_HEIGHT = hf_pkg::MAX_HEIGHT_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [hf_pkg::S_DATA_W-1:0]    s_tdata,   // blue, green, red
    input  logic                           s_tuser,   // filled
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [hf_pkg::M_DATA_W-1:0]    m_tdata,   // row, column, out_blue, out_green, out_red
    output logic                           m_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [hf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [hf_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic         push, full, pop, empty;
    hf_pkg::job_t push_job, head_job;

    hf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .push_job  (push_job),
        .full      (full)
    );

    hf_queue #(
        .DEPTH (hf_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .head_job (head_job),
        .empty    (empty)
    );

    hf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_job (head_job),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

>>> hdl/hf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module hf_ram #(
    parameter int WIDTH = 50,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/hf_queue.sv
// Short job queue between the front end and the result stage.
// Depends on hf_pkg for the job type and the assertion macros header.
`timescale 1ns / 1ps
`include "hole_fill_3x3_neighbor_average_defines.svh"

module hf_queue #(
    parameter int DEPTH = hf_pkg::QUEUE_DEPTH
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  hf_pkg::job_t push_job,
    output logic         full,
    input  logic         pop,
    output hf_pkg::job_t head_job,
    output logic         empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    hf_pkg::job_t    mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push, do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `HF_ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(DEPTH), "queue count beyond depth")

endmodule

>>> hdl/hf_front.sv
// Front end: input and configuration ports, frame position, line store, 3x3 window
// and neighbor sums; pushes one job per pixel that causes results.
// Depends on hf_pkg, hf_ram and the assertion macros header.
`timescale 1ns / 1ps
`include "hole_fill_3x3_neighbor_average_defines.svh"

module hf_front #(
    parameter int MAX_WIDTH  = hf_pkg::MAX_WIDTH_DEFAULT,
    parameter int MAX_HEIGHT = hf_pkg::MAX_HEIGHT_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [hf_pkg::S_DATA_W-1:0]    s_tdata,
    input  logic                           s_tuser,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [hf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [hf_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                           push,
    output hf_pkg::job_t                   push_job,
    input  logic                           full
);

    localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int LINE_DEPTH = 1 << XW;
    localparam int PW = hf_pkg::PIXEL_W;

    logic [WW-1:0] width_reg;
    logic [HW-1:0] height_reg;
    logic [XW-1:0] x_cnt_reg;
    logic [YW-1:0] y_cnt_reg;

    logic          st_valid_reg;
    hf_pkg::pixel_t st_pix_reg;
    logic [XW-1:0] st_x_reg;
    logic [YW-1:0] st_y_reg;
    logic          st_int_reg;
    logic          st_bdr_reg;

    hf_pkg::pixel_t win_reg [6];

    logic          accept, st_adv;
    logic [XW-1:0] x_eff;
    logic [YW-1:0] y_eff;
    logic [WW-1:0] x_inc;
    logic [HW-1:0] y_inc;
    logic          out_of_frame;
    logic          is_interior, is_border;
    hf_pkg::pixel_t cur_pix;

    logic [2*PW-1:0] line_rdata;
    hf_pkg::pixel_t  older, newer;
    hf_pkg::pixel_t  nb [9];
    logic [hf_pkg::SUM_W-1:0]   sum_r, sum_g, sum_b;
    logic [hf_pkg::COUNT_W-1:0] cnt;

    assign cfg_ready = 1'b1;
    assign st_adv    = st_valid_reg && !full;
    assign s_tready  = !st_valid_reg || st_adv;
    assign accept    = s_tvalid && s_tready;

    assign cur_pix = {s_tuser, s_tdata[23:16], s_tdata[15:8], s_tdata[7:0]};

    assign out_of_frame = (WW'(x_cnt_reg) >= width_reg) || (HW'(y_cnt_reg) >= height_reg);
    assign x_eff = out_of_frame ? '0 : x_cnt_reg;
    assign y_eff = out_of_frame ? '0 : y_cnt_reg;
    assign x_inc = WW'(x_eff) + 1'b1;
    assign y_inc = HW'(y_eff) + 1'b1;

    assign is_interior = (y_eff >= YW'(2)) && (x_eff >= XW'(2));
    assign is_border   = (y_eff == '0) || (HW'(y_eff) == height_reg - 1'b1)
                      || (x_eff == '0) || (WW'(x_eff) == width_reg - 1'b1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WW'(hf_pkg::clamp_size(32'(hf_pkg::FRAME_WIDTH_RESET), 32'(MAX_WIDTH)));
            height_reg <= HW'(hf_pkg::clamp_size(32'(hf_pkg::FRAME_HEIGHT_RESET),
                                                 32'(MAX_HEIGHT)));
            x_cnt_reg  <= '0;
            y_cnt_reg  <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                hf_pkg::CFG_FRAME_WIDTH: begin
                    width_reg <= WW'(hf_pkg::clamp_size(
                        32'(cfg_data[hf_pkg::CFG_WIDTH_W-1:0]), 32'(MAX_WIDTH)));
                    x_cnt_reg <= '0;
                    y_cnt_reg <= '0;
                end
                hf_pkg::CFG_FRAME_HEIGHT: begin
                    height_reg <= HW'(hf_pkg::clamp_size(32'(cfg_data), 32'(MAX_HEIGHT)));
                    x_cnt_reg  <= '0;
                    y_cnt_reg  <= '0;
                end
                default: begin
                end
            endcase
        end else if (accept) begin
            if (x_inc >= width_reg) begin
                x_cnt_reg <= '0;
                y_cnt_reg <= (y_inc >= height_reg) ? '0 : YW'(y_inc);
            end else begin
                x_cnt_reg <= XW'(x_inc);
                y_cnt_reg <= y_eff;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st_pix_reg <= cur_pix;
            st_x_reg   <= x_eff;
            st_y_reg   <= y_eff;
            st_int_reg <= is_interior;
            st_bdr_reg <= is_border;
        end
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= '0;
            end
        end else begin
            if (accept) begin
                st_valid_reg <= 1'b1;
            end else if (st_adv) begin
                st_valid_reg <= 1'b0;
            end
            if (st_adv) begin
                for (int i = 0; i < 3; i++) begin
                    win_reg[i] <= win_reg[i+3];
                end
                win_reg[3] <= older;
                win_reg[4] <= newer;
                win_reg[5] <= st_pix_reg;
            end
        end
    end

    // Each line store entry holds the two rows above the current one at that column.
    hf_ram #(
        .WIDTH (2 * PW),
        .DEPTH (LINE_DEPTH)
    ) u_line_store (
        .aclk  (aclk),
        .we    (st_adv),
        .waddr (st_x_reg),
        .wdata ({st_pix_reg, newer}),
        .re    (accept),
        .raddr (x_eff),
        .rdata (line_rdata)
    );

    assign older = line_rdata[PW-1:0];
    assign newer = line_rdata[2*PW-1:PW];

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            nb[i] = win_reg[i];
        end
        nb[6] = older;
        nb[7] = newer;
        nb[8] = st_pix_reg;
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        cnt   = '0;
        for (int i = 0; i < 9; i++) begin
            if (i != 4 && nb[i].filled) begin
                sum_r = sum_r + hf_pkg::SUM_W'(nb[i].red);
                sum_g = sum_g + hf_pkg::SUM_W'(nb[i].green);
                sum_b = sum_b + hf_pkg::SUM_W'(nb[i].blue);
                cnt   = cnt + 1'b1;
            end
        end
    end

    assign push = st_adv && (st_int_reg || st_bdr_reg);

    always_comb begin
        push_job.emit_interior = st_int_reg;
        push_job.emit_border   = st_bdr_reg;
        push_job.row           = hf_pkg::ROW_W'(st_y_reg);
        push_job.column        = hf_pkg::COLUMN_W'(st_x_reg);
        push_job.centre        = nb[4];
        push_job.current       = st_pix_reg;
        push_job.sum_red       = sum_r;
        push_job.sum_green     = sum_g;
        push_job.sum_blue      = sum_b;
        push_job.count         = cnt;
    end

    `HF_ASSERT_ALWAYS(a_pos_in_frame,
        (WW'(x_cnt_reg) < width_reg) && (HW'(y_cnt_reg) < height_reg),
        "frame position outside the configured frame")
    `HF_ASSERT_NEXT(a_stage_holds, st_valid_reg && full,
        st_valid_reg && $stable(st_pix_reg) && $stable(st_x_reg),
        "window stage changed while the queue was full")

endmodule

>>> hdl/hf_back.sv
// Result stage: takes jobs from the queue, divides the neighbor sums and emits
// the interior result and then the border result through an output register.
// Depends on hf_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "hole_fill_3x3_neighbor_average_defines.svh"

module hf_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  hf_pkg::job_t                head_job,
    input  logic                        empty,
    output logic                        pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [hf_pkg::M_DATA_W-1:0] m_tdata,
    output logic                        m_tlast
);

    localparam int RW = hf_pkg::ROW_W;
    localparam int CW = hf_pkg::COLUMN_W;

    logic                        m_valid_reg;
    logic [hf_pkg::M_DATA_W-1:0] m_data_reg;
    logic                        m_last_reg;

    logic          wk_valid_reg, wk_int_reg, wk_bdr_reg;
    logic [RW-1:0] wk_row_reg;
    logic [CW-1:0] wk_col_reg;
    logic [23:0]   wk_fill_reg;
    logic [23:0]   wk_cur_reg;

    logic          out_free, emit, wk_done, load;
    logic [hf_pkg::RECIP_W-1:0] rcp;
    logic [hf_pkg::PROD_W-1:0]  prod_r, prod_g, prod_b;
    logic          use_avg_r, use_avg_g, use_avg_b;
    logic [7:0]    fill_r, fill_g, fill_b;

    assign out_free = !m_valid_reg || m_tready;
    assign emit     = wk_valid_reg && out_free;
    assign wk_done  = emit && !(wk_int_reg && wk_bdr_reg);
    assign load     = !empty && (!wk_valid_reg || wk_done);
    assign pop      = load;

    assign rcp    = hf_pkg::recip(head_job.count);
    assign prod_r = hf_pkg::PROD_W'(head_job.sum_red) * hf_pkg::PROD_W'(rcp);
    assign prod_g = hf_pkg::PROD_W'(head_job.sum_green) * hf_pkg::PROD_W'(rcp);
    assign prod_b = hf_pkg::PROD_W'(head_job.sum_blue) * hf_pkg::PROD_W'(rcp);

    assign use_avg_r = !head_job.centre.filled && (head_job.sum_red != '0)
                    && (head_job.count != '0);
    assign use_avg_g = !head_job.centre.filled && (head_job.sum_green != '0)
                    && (head_job.count != '0);
    assign use_avg_b = !head_job.centre.filled && (head_job.sum_blue != '0)
                    && (head_job.count != '0);

    assign fill_r = use_avg_r ? prod_r[hf_pkg::RECIP_SHIFT +: 8] : head_job.centre.red;
    assign fill_g = use_avg_g ? prod_g[hf_pkg::RECIP_SHIFT +: 8] : head_job.centre.green;
    assign fill_b = use_avg_b ? prod_b[hf_pkg::RECIP_SHIFT +: 8] : head_job.centre.blue;

    always_ff @(posedge aclk) begin
        if (load) begin
            wk_row_reg  <= head_job.row;
            wk_col_reg  <= head_job.column;
            wk_fill_reg <= {fill_r, fill_g, fill_b};
            wk_cur_reg  <= {head_job.current.red, head_job.current.green,
                            head_job.current.blue};
        end
        if (emit) begin
            if (wk_int_reg) begin
                m_data_reg <= {2'b00, wk_fill_reg, wk_col_reg - 1'b1, wk_row_reg - 1'b1};
                m_last_reg <= !wk_bdr_reg;
            end else begin
                m_data_reg <= {2'b00, wk_cur_reg, wk_col_reg, wk_row_reg};
                m_last_reg <= 1'b1;
            end
        end
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            wk_valid_reg <= 1'b0;
            wk_int_reg   <= 1'b0;
            wk_bdr_reg   <= 1'b0;
        end else begin
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (load) begin
                wk_valid_reg <= 1'b1;
                wk_int_reg   <= head_job.emit_interior;
                wk_bdr_reg   <= head_job.emit_border;
            end else begin
                if (wk_done) begin
                    wk_valid_reg <= 1'b0;
                end
                if (emit) begin
                    if (wk_int_reg) begin
                        wk_int_reg <= 1'b0;
                    end else begin
                        wk_bdr_reg <= 1'b0;
                    end
                end
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    `HF_ASSERT_IMPLIES(a_work_pending, wk_valid_reg, wk_int_reg || wk_bdr_reg,
        "held job has no result left to emit")
    `HF_ASSERT_NEXT(a_interior_first, emit && wk_int_reg && wk_bdr_reg,
        wk_valid_reg && wk_bdr_reg && !wk_int_reg,
        "border result lost after interior result")

endmodule

>>> bench/tb_top.sv
// Self-checking bench for hole_fill_3x3_neighbor_average: streams RGB pixels with filled marks
// and compares every emitted pixel against a scoreboard that models the 3x3 neighbor average.
// Depends on hf_pkg and the hole_fill_3x3_neighbor_average RTL.
`timescale 1ns / 1ps

module tb_top;
    import hf_pkg::*;

    localparam int FRAME_MAX_W  = MAX_WIDTH_DEFAULT;
    localparam int FRAME_MAX_H  = MAX_HEIGHT_DEFAULT;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 120;
    localparam int MAX_BURST    = 30;
    localparam int HOLD_ITEMS   = 60;
    localparam int PRINT_LIMIT  = 100;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 8'hFF;

    typedef struct packed {
        logic [ROW_W-1:0]    row;
        logic [COLUMN_W-1:0] column;
        logic [7:0]          blue;
        logic [7:0]          green;
        logic [7:0]          red;
        logic                last;
    } fill_result_t;

    class hole_fill_scoreboard;
        logic [CFG_WIDTH_W-1:0] width_reg;
        logic [CFG_DATA_W-1:0]  height_reg;
        pixel_t                 line_mem [2*FRAME_MAX_W];
        pixel_t                 prev_columns [6];
        int unsigned            next_row;
        int unsigned            next_column;
        fill_result_t           pending [$];
        int                     errors;

        function new();
            width_reg   = CFG_WIDTH_W'(FRAME_WIDTH_RESET);
            height_reg  = CFG_DATA_W'(FRAME_HEIGHT_RESET);
            foreach (line_mem[i]) line_mem[i] = '0;
            foreach (prev_columns[i]) prev_columns[i] = '0;
            next_row    = 0;
            next_column = 0;
            errors      = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
            if (index == CFG_FRAME_WIDTH) begin
                width_reg = value[CFG_WIDTH_W-1:0];
            end else if (index == CFG_FRAME_HEIGHT) begin
                height_reg = value;
            end else begin
                return;
            end
            next_row    = 0;
            next_column = 0;
        endfunction

        function pixel_t neighbor_average(pixel_t win [9]);
            int unsigned sum_b, sum_g, sum_r, n;
            pixel_t res;
            res   = win[4];
            sum_b = 0;
            sum_g = 0;
            sum_r = 0;
            n     = 0;
            if (!win[4].filled) begin
                for (int i = 0; i < 9; i++) begin
                    if (i != 4 && win[i].filled) begin
                        sum_b += win[i].blue;
                        sum_g += win[i].green;
                        sum_r += win[i].red;
                        n++;
                    end
                end
                if (sum_b != 0 && n != 0) res.blue  = 8'(sum_b / n);
                if (sum_g != 0 && n != 0) res.green = 8'(sum_g / n);
                if (sum_r != 0 && n != 0) res.red   = 8'(sum_r / n);
            end
            return res;
        endfunction

        function void push_result(int unsigned r, int unsigned c, pixel_t p, logic last);
            fill_result_t item;
            item.row    = ROW_W'(r);
            item.column = COLUMN_W'(c);
            item.blue   = p.blue;
            item.green  = p.green;
            item.red    = p.red;
            item.last   = last;
            pending.push_back(item);
        endfunction

        function void note_pixel(pixel_t cur);
            int unsigned w, h, x, y, slot;
            pixel_t      col [3];
            pixel_t      win [9];
            logic        interior, border;
            w = (width_reg < 3) ? 3 : (width_reg > FRAME_MAX_W) ? FRAME_MAX_W : width_reg;
            h = (height_reg < 3) ? 3 : (height_reg > FRAME_MAX_H) ? FRAME_MAX_H : height_reg;
            x = next_column;
            y = next_row;
            if (x >= w || y >= h) begin
                x = 0;
                y = 0;
            end
            slot   = y & 1;
            col[0] = line_mem[slot*FRAME_MAX_W + x];
            col[1] = line_mem[(slot ^ 1)*FRAME_MAX_W + x];
            col[2] = cur;
            interior = (y >= 2 && x >= 2);
            border   = (y == 0 || y == h - 1 || x == 0 || x == w - 1);
            if (interior) begin
                for (int i = 0; i < 6; i++) win[i] = prev_columns[i];
                for (int i = 0; i < 3; i++) win[6+i] = col[i];
                push_result(y - 1, x - 1, neighbor_average(win), !border);
            end
            if (border) push_result(y, x, cur, 1'b1);
            line_mem[slot*FRAME_MAX_W + x] = cur;
            for (int i = 0; i < 3; i++) begin
                prev_columns[i]     = prev_columns[i+3];
                prev_columns[i+3]   = col[i];
            end
            x++;
            if (x >= w) begin
                x = 0;
                y++;
                if (y >= h) y = 0;
            end
            next_column = x;
            next_row    = y;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= PRINT_LIMIT) $display("ERROR: %s", msg);
        endtask

        task check_result(logic [M_DATA_W-1:0] data, logic last);
            fill_result_t got, want;
            got.row    = data[11:0];
            got.column = data[21:12];
            got.blue   = data[29:22];
            got.green  = data[37:30];
            got.red    = data[45:38];
            got.last   = last;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result at row %0d column %0d",
                                 got.row, got.column));
                return;
            end
            want = pending.pop_front();
            if (got.row != want.row)
                report($sformatf("row %0d, wanted %0d", got.row, want.row));
            if (got.column != want.column)
                report($sformatf("column %0d, wanted %0d", got.column, want.column));
            if (got.blue != want.blue)
                report($sformatf("blue %0d at (%0d,%0d), wanted %0d",
                                 got.blue, want.row, want.column, want.blue));
            if (got.green != want.green)
                report($sformatf("green %0d at (%0d,%0d), wanted %0d",
                                 got.green, want.row, want.column, want.green));
            if (got.red != want.red)
                report($sformatf("red %0d at (%0d,%0d), wanted %0d",
                                 got.red, want.row, want.column, want.red));
            if (got.last != want.last)
                report($sformatf("last %0d at (%0d,%0d), wanted %0d",
                                 got.last, want.row, want.column, want.last));
        endtask
    endclass

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_DATA_W-1:0]    m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    hole_fill_scoreboard board;
    bit                  source_steady = 1'b0;
    bit                  hold_request  = 1'b0;

    hole_fill_3x3_neighbor_average dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic pixel_t make_pixel(logic f, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        pixel_t p;
        p.filled = f;
        p.red    = r;
        p.green  = g;
        p.blue   = b;
        return p;
    endfunction

    function automatic logic [7:0] random_level();
        logic [7:0] v;
        case ($urandom_range(0, 7))
            0:       v = 8'd0;
            1:       v = 8'd255;
            default: v = 8'($urandom_range(0, 255));
        endcase
        return v;
    endfunction

    function automatic pixel_t random_pixel(int fill_pct, logic [2:0] zero_channels);
        pixel_t p;
        p.filled = ($urandom_range(0, 99) < fill_pct);
        p.blue   = zero_channels[0] ? 8'd0 : random_level();
        p.green  = zero_channels[1] ? 8'd0 : random_level();
        p.red    = zero_channels[2] ? 8'd0 : random_level();
        return p;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_size(int bits);
        logic [CFG_DATA_W-1:0] v;
        case ($urandom_range(0, 19))
            0:       v = CFG_DATA_W'($urandom_range(0, 2));
            1:       v = CFG_DATA_W'($urandom_range(0, (1 << bits) - 1));
            default: v = CFG_DATA_W'($urandom_range(3, 9));
        endcase
        return v;
    endfunction

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        board.write_reg(index, value);
    endtask

    task automatic send_pixel(input pixel_t p);
        int gap;
        gap = source_steady ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {p.red, p.green, p.blue};
        s_tuser  <= p.filled;
        do @(posedge aclk); while (!s_tready);
        board.note_pixel(p);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int          held;
        int          gap;
        int unsigned taken;
        taken = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++) @(posedge aclk);
            end
            gap = (taken % 80 < 25) ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            board.check_result(m_tdata, m_tlast);
            taken++;
        end
    end

    initial begin
        int         random_items;
        int         phase;
        int         count;
        int         choice;
        int         fill_pct;
        logic [2:0] zero_channels;
        board = new();
        random_items = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Undersized registers saturate to a 3x3 frame whose hole center sees eight filled
        // neighbors; red is zero in all of them, so the center keeps its own red.
        write_register(CFG_FRAME_WIDTH, 13'd0);
        write_register(CFG_FRAME_HEIGHT, 13'd1);
        cfg_valid <= 1'b0;
        for (int i = 0; i < 9; i++) begin
            if (i == 4) send_pixel(make_pixel(1'b0, 8'hAB, 8'hCD, 8'h12));
            else send_pixel(make_pixel(1'b1, 8'd0, 8'(i * 37), 8'd255));
        end
        wait_idle();

        // A 4x3 frame: one hole with three filled neighbors, one hole with none, then the
        // stream wraps into the next frame.
        write_register(CFG_UNUSED_INDEX, 13'h1FFF);
        write_register(CFG_FRAME_WIDTH, 13'd4);
        write_register(CFG_FRAME_HEIGHT, 13'd3);
        cfg_valid <= 1'b0;
        for (int i = 0; i < 14; i++)
            send_pixel(make_pixel(i == 0 || i == 4 || i == 8,
                                  8'(i * 23), 8'(255 - i * 21), 8'(i * 19)));
        wait_idle();

        // Oversized width saturates to the widest frame; run past the first row end.
        write_register(CFG_FRAME_WIDTH, 13'd2047);
        write_register(CFG_FRAME_HEIGHT, 13'd8191);
        cfg_valid <= 1'b0;
        source_steady = 1'b1;
        for (int i = 0; i < FRAME_MAX_W + 6; i++) send_pixel(random_pixel(60, 3'b000));

        phase = 0;
        while (random_items < RANDOM_ITEMS) begin
            wait_idle();
            choice = $urandom_range(0, 9);
            if (phase % 9 == 1) begin
                write_register(CFG_FRAME_WIDTH, 13'd5);
                write_register(CFG_FRAME_HEIGHT, 13'd7);
            end else if (choice != 0) begin
                if (choice != 1) write_register(CFG_FRAME_WIDTH, random_size(CFG_WIDTH_W));
                if (choice != 2) write_register(CFG_FRAME_HEIGHT, random_size(CFG_DATA_W));
            end
            cfg_valid <= 1'b0;
            source_steady = ($urandom_range(0, 3) == 0);
            count = $urandom_range(1, MAX_BURST);
            if (phase % 9 == 1) begin
                hold_request = 1'b1;
                source_steady = 1'b1;
                count = HOLD_ITEMS;
            end
            case ($urandom_range(0, 5))
                0:       fill_pct = 0;
                1:       fill_pct = 100;
                default: fill_pct = $urandom_range(10, 90);
            endcase
            zero_channels = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(1, 7)) : 3'b000;
            for (int i = 0; i < count; i++) send_pixel(random_pixel(fill_pct, zero_channels));
            random_items += count;
            phase++;
        end

        wait_idle();
        if (board.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
